### hdl/double_buffered_allreduce_accumulator_macros.svh
// assertion macros shared by the accumulator rtl
`ifndef DOUBLE_BUFFERED_ALLREDUCE_ACCUMULATOR_MACROS_SVH
`define DOUBLE_BUFFERED_ALLREDUCE_ACCUMULATOR_MACROS_SVH

// same-cycle implication, held off during reset
`define DBAR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define DBAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dbar_pkg.sv
// types, constants and codes of the allreduce accumulator
package dbar_pkg;

    localparam int MAX_PEERS    = 64;
    localparam int MAX_ELEMENTS = 4096;

    localparam int PEER_AW = $clog2(MAX_PEERS);
    localparam int ELEM_AW = $clog2(MAX_ELEMENTS);
    localparam int ACC_AW  = ELEM_AW + 1;

    // field widths of the channels
    localparam int OP_W     = 2;
    localparam int SRC_W    = 6;
    localparam int IDX_W    = 12;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int RANK_W   = 6;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_CONTRIB = 2'd0;
    localparam logic [OP_W-1:0] OP_PREPARE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OP_MISMATCH    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WIDTH_MISMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DROPPED        = 3'd4;

    // register indexes
    localparam logic REG_PEER_COUNT = 1'b0;
    localparam logic REG_MY_RANK    = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [SRC_W-1:0] source;
        logic             first_element;
        logic             last_element;
        logic             op_kind;
        logic             wide;
        logic [IDX_W-1:0] element_index;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic              wr_en;
        logic [ACC_AW-1:0] wr_addr;
        logic [VAL_W-1:0]  wr_data;
        logic [ACC_AW-1:0] rd_addr;
    } t_acc_req;

    typedef struct packed {
        logic               wr_en;
        logic [PEER_AW-1:0] wr_addr;
        logic               wr_data;
        logic [PEER_AW-1:0] rd_addr;
    } t_turn_req;

endpackage

### hdl/dbar_if.sv
// input and output channel interfaces of the allreduce accumulator
interface dbar_in_if import dbar_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [SRC_W-1:0] src_peer;
    logic             first_element;
    logic             last_element;
    logic             op_kind;
    logic             wide;
    logic [IDX_W-1:0] element_index;
    logic [VAL_W-1:0] value;

    modport source (
        output valid, operation, src_peer, first_element, last_element, op_kind, wide,
               element_index, value,
        input  ready
    );
    modport sink (
        input  valid, operation, src_peer, first_element, last_element, op_kind, wide,
               element_index, value,
        output ready
    );
endinterface

interface dbar_out_if import dbar_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    result_value;
    logic                all_arrived;
    logic                current_turn;

    modport source (
        output valid, status, result_value, all_arrived, current_turn,
        input  ready
    );
    modport sink (
        input  valid, status, result_value, all_arrived, current_turn,
        output ready
    );
endinterface

### hdl/dbar_acc_store.sv
// accumulator memory: both turn buffers, one write and one registered read per cycle
module dbar_acc_store import dbar_pkg::*; (
    input  logic             i_clk,
    input  t_acc_req         i_req,
    output logic [VAL_W-1:0] o_rd_data
);

    logic [VAL_W-1:0] r_mem [2*MAX_ELEMENTS];
    logic [VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/dbar_turn_store.sv
// per-peer turn bits, one write and one registered read per cycle
module dbar_turn_store import dbar_pkg::*; (
    input  logic      i_clk,
    input  t_turn_req i_req,
    output logic      o_rd_data
);

    logic r_mem [MAX_PEERS];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/double_buffered_allreduce_accumulator.sv
// top level: control sequencer, config registers and output register of the accumulator
//
//  channel  | dir | handshake        | beat contents
//  ---------+-----+------------------+------------------------------------------------
//  i_in     | in  | valid/ready      | operation, source, first/last, op_kind, wide,
//           |     |                  | element_index, value
//  o_out    | out | valid/ready      | status, result_value, all_arrived, current_turn
//  apb      | in  | psel/penable     | peer_count at 0x0, my_rank at 0x4
//
// a contribute beat steps through decode, turn/count check, accumulator read-modify-write and
// output; a read skips the read-modify-write, an unused code goes from decode to output, and
// idle is entered before the next beat is taken. a prepare sweeps all MAX_ELEMENTS (4096)
// entries of the other turn buffer before its output. after reset a clearing pass writes all
// 2*MAX_ELEMENTS entries (8192) before the first beat is taken. a stalled output holds the
// sequencer in its output step; one finished result may wait in the output register while idle.
`include "double_buffered_allreduce_accumulator_macros.svh"

module double_buffered_allreduce_accumulator import dbar_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dbar_in_if.sink           i_in,
    dbar_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;
    localparam logic [2:0] S_PCLR  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]          r_state;
    logic [ACC_AW-1:0]   r_clr_addr;
    t_in_item            r_item;
    logic [COUNT_W-1:0]  r_peer_count;
    logic [RANK_W-1:0]   r_my_rank;
    logic [COUNT_W-1:0]  r_pending [2];
    logic                r_rec_op [2];
    logic                r_rec_wide [2];
    logic                r_active;
    logic                r_msg_open;
    logic                r_local;
    logic [STATUS_W-1:0] r_status;
    logic [VAL_W-1:0]    r_result;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [VAL_W-1:0]    r_out_result;
    logic                r_out_arrived;
    logic                r_out_turn;

    t_acc_req            acc_req;
    t_turn_req           turn_req;
    logic [VAL_W-1:0]    acc_rd;
    logic                pt_rd;

    logic                in_fire;
    logic                out_free;
    logic                src_ok;
    logic                idx_ok;
    logic                rank_ok;
    logic                is_contrib;
    logic                first;
    logic                ev_turn;
    logic [COUNT_W-1:0]  ev_pc;
    logic                ev_open_ok;
    logic [STATUS_W-1:0] ev_status;
    logic                prep_turn;
    logic                apply_op;
    logic                apply_wide;
    logic [VAL_W-1:0]    apply_val;
    logic                cfg_wr;

    function automatic logic [VAL_W-1:0] f_apply(input logic [VAL_W-1:0] acc,
                                                 input logic [VAL_W-1:0] v,
                                                 input logic op, input logic wd);
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        logic [VAL_W-1:0] r;
        a = wd ? acc : {32'b0, acc[31:0]};
        b = wd ? v : {32'b0, v[31:0]};
        r = op ? ((b > a) ? b : a) : (a + b);
        if (!wd) begin
            r = {32'b0, r[31:0]};
        end
        return r;
    endfunction

    dbar_acc_store u_acc (
        .i_clk     (i_clk),
        .i_req     (acc_req),
        .o_rd_data (acc_rd)
    );

    dbar_turn_store u_turn (
        .i_clk     (i_clk),
        .i_req     (turn_req),
        .o_rd_data (pt_rd)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    assign src_ok     = 32'(r_item.source) < MAX_PEERS;
    assign idx_ok     = 32'(r_item.element_index) < MAX_ELEMENTS;
    assign rank_ok    = 32'(r_my_rank) < MAX_PEERS;
    assign is_contrib = (r_item.operation == OP_CONTRIB);
    assign first      = r_item.first_element;
    assign prep_turn  = rank_ok ? pt_rd : 1'b0;

    // header check of a contribution; continuation beats ride on the open one
    always_comb begin
        ev_turn    = first ? pt_rd : r_active;
        ev_pc      = r_pending[pt_rd];
        ev_open_ok = 1'b0;
        ev_status  = ST_OK;
        if (first) begin
            if (!src_ok) begin
                ev_status = ST_DROPPED;
            end else if (ev_pc == '0 || ev_pc > r_peer_count) begin
                ev_status = ST_BAD_COUNT;
            end else if (ev_pc != r_peer_count && r_rec_op[pt_rd] != r_item.op_kind) begin
                ev_status = ST_OP_MISMATCH;
            end else if (ev_pc != r_peer_count && r_rec_wide[pt_rd] != r_item.wide) begin
                ev_status = ST_WIDTH_MISMATCH;
            end else begin
                ev_open_ok = 1'b1;
            end
        end else if (!r_msg_open) begin
            ev_status = ST_DROPPED;
        end else begin
            ev_open_ok = 1'b1;
        end
        if (ev_open_ok && !idx_ok) begin
            ev_status = ST_DROPPED;
        end
    end

    assign apply_op   = r_rec_op[r_active];
    assign apply_wide = r_rec_wide[r_active];
    assign apply_val  = f_apply(acc_rd, r_item.value, apply_op, apply_wide);

    always_comb begin
        acc_req.wr_en   = 1'b0;
        acc_req.wr_addr = {r_active, r_item.element_index[ELEM_AW-1:0]};
        acc_req.wr_data = apply_val;
        if (r_state == S_DEC) begin
            acc_req.rd_addr = {r_local, r_item.element_index[ELEM_AW-1:0]};
        end else begin
            acc_req.rd_addr = {ev_turn, r_item.element_index[ELEM_AW-1:0]};
        end
        unique case (r_state)
            S_CLR: begin
                acc_req.wr_en   = 1'b1;
                acc_req.wr_addr = r_clr_addr;
                acc_req.wr_data = '0;
            end
            S_PCLR: begin
                acc_req.wr_en   = 1'b1;
                acc_req.wr_addr = {~r_local, r_clr_addr[ELEM_AW-1:0]};
                acc_req.wr_data = '0;
            end
            S_APPLY: begin
                acc_req.wr_en = 1'b1;
            end
            default: begin
                acc_req.wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        turn_req.rd_addr = (r_item.operation == OP_PREPARE) ? r_my_rank[PEER_AW-1:0]
                                                             : r_item.source[PEER_AW-1:0];
        if (r_state == S_CLR) begin
            turn_req.wr_en   = 1'b1;
            turn_req.wr_addr = r_clr_addr[PEER_AW-1:0];
            turn_req.wr_data = 1'b0;
        end else begin
            turn_req.wr_en   = (r_state == S_EVAL) && is_contrib && first && src_ok;
            turn_req.wr_addr = r_item.source[PEER_AW-1:0];
            turn_req.wr_data = ~pt_rd;
        end
    end

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_PEER_COUNT: prdata = {{(APB_DW-COUNT_W){1'b0}}, r_peer_count};
            REG_MY_RANK:    prdata = {{(APB_DW-RANK_W){1'b0}}, r_my_rank};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer_count <= COUNT_W'(2);
            r_my_rank    <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PEER_COUNT: r_peer_count <= pwdata[COUNT_W-1:0];
                REG_MY_RANK:    r_my_rank    <= pwdata[RANK_W-1:0];
                default:        r_my_rank    <= r_my_rank;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.operation     <= i_in.operation;
            r_item.source        <= i_in.src_peer;
            r_item.first_element <= i_in.first_element;
            r_item.last_element  <= i_in.last_element;
            r_item.op_kind       <= i_in.op_kind;
            r_item.wide          <= i_in.wide;
            r_item.element_index <= i_in.element_index;
            r_item.value         <= i_in.value;
        end
        if (r_state == S_DEC) begin
            r_status <= ST_OK;
            r_result <= '0;
        end
        if (r_state == S_EVAL) begin
            if (is_contrib) begin
                r_status <= ev_status;
            end else if (r_item.operation == OP_READ) begin
                r_status <= idx_ok ? ST_OK : ST_DROPPED;
                r_result <= idx_ok ? acc_rd : '0;
            end
        end
        if (r_state == S_OUT && out_free) begin
            r_out_status  <= r_status;
            r_out_result  <= r_result;
            r_out_arrived <= (r_pending[r_local] == '0);
            r_out_turn    <= is_contrib ? r_active : r_local;
        end
    end

    // sequencer and turn state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_clr_addr    <= '0;
            r_pending[0]  <= COUNT_W'(2);
            r_pending[1]  <= COUNT_W'(2);
            r_rec_op[0]   <= 1'b0;
            r_rec_op[1]   <= 1'b0;
            r_rec_wide[0] <= 1'b0;
            r_rec_wide[1] <= 1'b0;
            r_active      <= 1'b0;
            r_msg_open    <= 1'b0;
            r_local       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_item.operation == OP_CONTRIB || r_item.operation == OP_PREPARE
                            || r_item.operation == OP_READ) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_EVAL: begin
                    if (is_contrib) begin
                        if (first && src_ok) begin
                            r_active <= pt_rd;
                        end
                        if (first && ev_open_ok) begin
                            r_pending[pt_rd] <= ev_pc - 1'b1;
                            if (ev_pc == r_peer_count) begin
                                r_rec_op[pt_rd]   <= r_item.op_kind;
                                r_rec_wide[pt_rd] <= r_item.wide;
                            end
                        end
                        // an errored header closes whatever was open
                        if (ev_open_ok) begin
                            r_msg_open <= !r_item.last_element;
                        end else if (first) begin
                            r_msg_open <= 1'b0;
                        end
                        r_state <= (ev_open_ok && idx_ok) ? S_APPLY : S_OUT;
                    end else if (r_item.operation == OP_PREPARE) begin
                        r_local              <= prep_turn;
                        r_pending[~prep_turn] <= r_peer_count;
                        r_clr_addr           <= '0;
                        r_state              <= S_PCLR;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_APPLY: begin
                    r_state <= S_OUT;
                end
                S_PCLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr[ELEM_AW-1:0]) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.result_value = r_out_result;
    assign o_out.all_arrived  = r_out_arrived;
    assign o_out.current_turn = r_out_turn;

    `DBAR_ASSERT_NOW(a_no_acc_write_idle, i_clk, i_rst_n, r_state == S_IDLE, !acc_req.wr_en, "accumulator written while idle")
    `DBAR_ASSERT_NOW(a_prep_clears_other, i_clk, i_rst_n, r_state == S_PCLR, acc_req.wr_addr[ACC_AW-1] != r_local, "prepare clear hits local turn")
    `DBAR_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, in_fire, r_state == S_DEC && !in_fire, "accepted beat not decoded")
    `DBAR_ASSERT_NEXT(a_out_stall_holds, i_clk, i_rst_n, r_state == S_OUT && r_out_valid && !o_out.ready, r_state == S_OUT && r_out_valid, "result lost while output stalled")

endmodule
